// ----- rtl/tpbt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the turtle path bounds tracker.
package tpbt_pkg;

    // Default sizes of the turtle stack and of the CORDIC rotation.
    localparam int TPBT_STACK_DEPTH  = 64;
    localparam int TPBT_CORDIC_STEPS = 16;

    // Data widths.
    localparam int POS_W     = 32;
    localparam int HEAD_W    = 16;
    localparam int CORDIC_W  = 34;
    localparam int STEP_W    = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // CORDIC start value: the inverse gain in Q2.30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    // Rounding offset before the drop from Q2.30 to Q16.16.
    localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 34'sd8192;
    localparam int ROUND_SHIFT = 14;

    // Register reset values.
    localparam logic [HEAD_W-1:0] TURN_ANGLE_RST    = 16'd7282;
    localparam logic [HEAD_W-1:0] START_HEADING_RST = 16'd16384;

    // Register indexes, taken from the word address bit.
    localparam logic REG_TURN_ANGLE    = 1'b0;
    localparam logic REG_START_HEADING = 1'b1;

    // Command bytes.
    localparam logic [7:0] CH_DRAW  = 8'h46;  // F
    localparam logic [7:0] CH_SKIP  = 8'h66;  // f
    localparam logic [7:0] CH_LEFT  = 8'h2D;  // -
    localparam logic [7:0] CH_RIGHT = 8'h2B;  // +
    localparam logic [7:0] CH_PUSH  = 8'h5B;  // [
    localparam logic [7:0] CH_POP   = 8'h5D;  // ]

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } tpbt_status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROTATE,
        ST_ROUND,
        ST_MOVE,
        ST_BOUND,
        ST_POP,
        ST_FINISH
    } tpbt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decode;
        logic rotate;
        logic round;
        logic move;
        logic bound;
        logic pop_wb;
        logic emit;
    } tpbt_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_move;
        logic pop_ok;
        logic rotate_last;
        logic out_free;
    } tpbt_stat_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/tpbt_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command words and result words.
interface tpbt_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_char;
    logic       restart;

    modport source (output valid, output cmd_char, output restart, input ready);
    modport sink   (input valid, input cmd_char, input restart, output ready);
endinterface

interface tpbt_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               segment_drawn;
    logic               pen_jump;
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
    logic [1:0]         status;

    modport source (output valid, output pos_x, output pos_y, output segment_drawn,
                    output pen_jump, output min_x, output max_x, output min_y,
                    output max_y, output status, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input segment_drawn,
                    input pen_jump, input min_x, input max_x, input min_y,
                    input max_y, input status, output ready);
endinterface

// ----- rtl/tpbt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the turtle path bounds tracker.
module tpbt_ctrl
    import tpbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  tpbt_stat_t stat,
    output tpbt_ctl_t  ctl
);

    tpbt_state_t state_reg;
    tpbt_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                ctl.decode = 1'b1;
                if (stat.is_move)
                begin
                    state_next = ST_ROTATE;
                end
                else if (stat.pop_ok)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ROTATE:
            begin
                ctl.rotate = 1'b1;
                if (stat.rotate_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                ctl.round  = 1'b1;
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                ctl.move   = 1'b1;
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                ctl.bound  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_POP:
            begin
                ctl.pop_wb = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tpbt_dp.sv -----
`timescale 1ns / 1ps
// Datapath: turtle state, CORDIC unit, bounds, stack memory and result register.
module tpbt_dp
    import tpbt_pkg::*;
#(
    parameter int STACK_DEPTH  = TPBT_STACK_DEPTH,
    parameter int CORDIC_STEPS = TPBT_CORDIC_STEPS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        cmd_char,
    input  logic              restart,
    input  logic [HEAD_W-1:0] turn_angle,
    input  logic [HEAD_W-1:0] start_heading,
    input  tpbt_ctl_t         ctl,
    output tpbt_stat_t        stat,
    tpbt_res_if.source        res
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam int ENTRY_W = 2 * POS_W + HEAD_W;

    // Turtle state.
    logic signed [POS_W-1:0] cur_x_reg, cur_y_reg;
    logic [HEAD_W-1:0]       heading_reg;
    logic signed [POS_W-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic [FILL_W-1:0]       fill_reg;

    // Command and per-word flags.
    logic [7:0]   cmd_reg;
    logic         drawn_reg, jump_reg;
    tpbt_status_t status_reg;

    // CORDIC unit.
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic                       flip_reg;
    logic signed [STEP_W-1:0]   step_x_reg, step_y_reg;

    // Stack memory.
    logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Result register.
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] o_x_reg, o_y_reg, o_lo_x_reg, o_hi_x_reg, o_lo_y_reg, o_hi_y_reg;
    logic                    o_drawn_reg, o_jump_reg;
    logic [1:0]              o_status_reg;
    logic                    out_valid_next;

    // Combinational helpers.
    logic                     is_move, is_pop, is_push, stack_full, stack_empty;
    logic [FILL_W-1:0]        fill_m1;
    logic [IDX_W-1:0]         push_idx, pop_idx;
    logic [HEAD_W-1:0]        head_flip;
    logic                     flip_now;
    logic signed [CORDIC_W-1:0] atan_ext, dx, dy;
    logic signed [CORDIC_W-1:0] fx, fy, rx, ry;
    logic signed [POS_W:0]    sum_x, sum_y;
    logic signed [POS_W-1:0]  new_x, new_y;
    logic signed [POS_W-1:0]  pop_x, pop_y;
    logic [HEAD_W-1:0]        pop_h;

    function automatic logic head_flip_bit(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] t;
        t = h + 16'h4000;
        return t[HEAD_W-1];
    endfunction

    // Command decode and stack pointers.
    assign is_move     = (cmd_reg == CH_DRAW) || (cmd_reg == CH_SKIP);
    assign is_pop      = (cmd_reg == CH_POP);
    assign is_push     = (cmd_reg == CH_PUSH);
    assign stack_full  = (fill_reg == FILL_W'(STACK_DEPTH));
    assign stack_empty = (fill_reg == '0);
    assign fill_m1     = fill_reg - 1'b1;
    assign push_idx    = fill_reg[IDX_W-1:0];
    assign pop_idx     = fill_m1[IDX_W-1:0];

    assign stat.is_move     = is_move;
    assign stat.pop_ok      = is_pop && !stack_empty;
    assign stat.rotate_last = (iter_reg == ITER_W'(CORDIC_STEPS - 1));
    assign stat.out_free    = !out_valid_reg || res.ready;

    // Headings in the left half turn are rotated by half a turn first.
    assign flip_now  = head_flip_bit(heading_reg);
    assign head_flip = flip_now ? (heading_reg ^ 16'h8000) : heading_reg;

    // One CORDIC micro-rotation.
    assign atan_ext = CORDIC_W'(atan_turns(5'(iter_reg)));
    assign dx       = cy_reg >>> iter_reg;
    assign dy       = cx_reg >>> iter_reg;

    // Undo the half-turn and round to Q16.16.
    assign fx = flip_reg ? -cx_reg : cx_reg;
    assign fy = flip_reg ? -cy_reg : cy_reg;
    assign rx = (fx + ROUND_HALF) >>> ROUND_SHIFT;
    assign ry = (fy + ROUND_HALF) >>> ROUND_SHIFT;

    // Saturating position update.
    assign sum_x = {cur_x_reg[POS_W-1], cur_x_reg}
                 + {{(POS_W + 1 - STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
    assign sum_y = {cur_y_reg[POS_W-1], cur_y_reg}
                 + {{(POS_W + 1 - STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
    assign new_x = (sum_x[POS_W] != sum_x[POS_W-1])
                 ? (sum_x[POS_W] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_x[POS_W-1:0];
    assign new_y = (sum_y[POS_W] != sum_y[POS_W-1])
                 ? (sum_y[POS_W] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_y[POS_W-1:0];

    // Fields of a popped stack entry.
    assign pop_x = rd_data_reg[ENTRY_W-1 -: POS_W];
    assign pop_y = rd_data_reg[HEAD_W +: POS_W];
    assign pop_h = rd_data_reg[HEAD_W-1:0];

    // Turtle state, bounds and stack fill.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            heading_reg <= START_HEADING_RST;
            lo_x_reg    <= '0;
            hi_x_reg    <= '0;
            lo_y_reg    <= '0;
            hi_y_reg    <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (ctl.load && restart)
            begin
                cur_x_reg   <= '0;
                cur_y_reg   <= '0;
                heading_reg <= start_heading;
                lo_x_reg    <= '0;
                hi_x_reg    <= '0;
                lo_y_reg    <= '0;
                hi_y_reg    <= '0;
                fill_reg    <= '0;
            end
            if (ctl.decode)
            begin
                if (cmd_reg == CH_LEFT)
                begin
                    heading_reg <= heading_reg + turn_angle;
                end
                else if (cmd_reg == CH_RIGHT)
                begin
                    heading_reg <= heading_reg - turn_angle;
                end
                if (is_push && !stack_full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else if (is_pop && !stack_empty)
                begin
                    fill_reg <= fill_m1;
                end
            end
            if (ctl.move)
            begin
                cur_x_reg <= new_x;
                cur_y_reg <= new_y;
            end
            if (ctl.bound)
            begin
                if (cur_x_reg < lo_x_reg) lo_x_reg <= cur_x_reg;
                if (cur_x_reg > hi_x_reg) hi_x_reg <= cur_x_reg;
                if (cur_y_reg < lo_y_reg) lo_y_reg <= cur_y_reg;
                if (cur_y_reg > hi_y_reg) hi_y_reg <= cur_y_reg;
            end
            if (ctl.pop_wb)
            begin
                cur_x_reg   <= pop_x;
                cur_y_reg   <= pop_y;
                heading_reg <= pop_h;
            end
        end
    end

    // Command word, per-word flags and the CORDIC registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd_char;
            drawn_reg  <= 1'b0;
            jump_reg   <= 1'b0;
            status_reg <= STAT_OK;
        end
        if (ctl.decode)
        begin
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= {{(CORDIC_W - 32){head_flip[HEAD_W-1]}}, head_flip, 16'h0000};
            flip_reg <= flip_now;
            iter_reg <= '0;
            if (is_push && stack_full)
            begin
                status_reg <= STAT_PUSH_FULL;
            end
            if (is_pop && stack_empty)
            begin
                status_reg <= STAT_POP_EMPTY;
            end
        end
        if (ctl.rotate)
        begin
            if (!cz_reg[CORDIC_W-1])
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_ext;
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_ext;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (ctl.round)
        begin
            step_x_reg <= rx[STEP_W-1:0];
            step_y_reg <= ry[STEP_W-1:0];
        end
        if (ctl.move)
        begin
            if (cmd_reg == CH_DRAW)
            begin
                drawn_reg <= 1'b1;
            end
            else
            begin
                jump_reg <= (new_x != cur_x_reg) || (new_y != cur_y_reg);
            end
        end
        if (ctl.pop_wb)
        begin
            jump_reg <= (pop_x != cur_x_reg) || (pop_y != cur_y_reg);
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.decode && is_push && !stack_full)
        begin
            stack_mem[push_idx] <= {cur_x_reg, cur_y_reg, heading_reg};
        end
        if (ctl.decode && is_pop && !stack_empty)
        begin
            rd_data_reg <= stack_mem[pop_idx];
        end
    end

    // Result word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            o_x_reg      <= cur_x_reg;
            o_y_reg      <= cur_y_reg;
            o_lo_x_reg   <= lo_x_reg;
            o_hi_x_reg   <= hi_x_reg;
            o_lo_y_reg   <= lo_y_reg;
            o_hi_y_reg   <= hi_y_reg;
            o_drawn_reg  <= drawn_reg;
            o_jump_reg   <= jump_reg;
            o_status_reg <= status_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.pos_x         = o_x_reg;
    assign res.pos_y         = o_y_reg;
    assign res.segment_drawn = o_drawn_reg;
    assign res.pen_jump      = o_jump_reg;
    assign res.min_x         = o_lo_x_reg;
    assign res.max_x         = o_hi_x_reg;
    assign res.min_y         = o_lo_y_reg;
    assign res.max_y         = o_hi_y_reg;
    assign res.status        = o_status_reg;

endmodule

// ----- rtl/turtle_path_bounds_tracker_core.sv -----
`timescale 1ns / 1ps
// Top level of the turtle path bounds tracker: register port, controller and datapath.
//
// One command word at a time is interpreted. F and f pass through the accepting cycle,
// decode, CORDIC_STEPS micro-rotations in the shared CORDIC unit, which does one
// micro-rotation per cycle, then rounding, the saturating move, the bounds update and
// the result load. Turns, pushes, ignored bytes and pops that find the stack empty go
// from decode to the result load; other pops pass the stack write-back in between.
// A new command word is accepted the cycle after the result load, while that result
// word may still wait in the output register; a result word that is still waiting
// when the next one is ready holds the controller until it is taken. The stack holds
// STACK_DEPTH entries in a memory with one write port and one registered read port
// and needs no clearing after reset.
module turtle_path_bounds_tracker_core
    import tpbt_pkg::*;
#(
    parameter int STACK_DEPTH  = TPBT_STACK_DEPTH,
    parameter int CORDIC_STEPS = TPBT_CORDIC_STEPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tpbt_cmd_if.sink              cmd,
    tpbt_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [HEAD_W-1:0] turn_angle_reg;
    logic [HEAD_W-1:0] start_heading_reg;
    logic              cfg_write;
    logic              in_ready;
    tpbt_ctl_t         ctl;
    tpbt_stat_t        stat;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_angle_reg    <= TURN_ANGLE_RST;
            start_heading_reg <= START_HEADING_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_TURN_ANGLE:    turn_angle_reg    <= pwdata[HEAD_W-1:0];
                REG_START_HEADING: start_heading_reg <= pwdata[HEAD_W-1:0];
                default:           turn_angle_reg    <= turn_angle_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[2])
            REG_TURN_ANGLE:    prdata = {{(CFG_DATA_W - HEAD_W){1'b0}}, turn_angle_reg};
            REG_START_HEADING: prdata = {{(CFG_DATA_W - HEAD_W){1'b0}}, start_heading_reg};
            default:           prdata = '0;
        endcase
    end

    assign cmd.ready = in_ready;

    // Sequencer.
    tpbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath.
    tpbt_dp #(
        .STACK_DEPTH  (STACK_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_char      (cmd.cmd_char),
        .restart       (cmd.restart),
        .turn_angle    (turn_angle_reg),
        .start_heading (start_heading_reg),
        .ctl           (ctl),
        .stat          (stat),
        .res           (res)
    );

endmodule

// ----- rtl/tpbt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the turtle path bounds tracker and its bind to the top level.
module tpbt_checker
    import tpbt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic               segment_drawn,
    input logic               pen_jump,
    input logic signed [31:0] min_x,
    input logic signed [31:0] max_x,
    input logic signed [31:0] min_y,
    input logic signed [31:0] max_y,
    input logic [1:0]         status
);

    // A stalled result word keeps its position.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(pos_x) && $stable(pos_y))
        else $error("result word changed while stalled");

    // The position always lies inside the reported bounds.
    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> min_x <= pos_x && pos_x <= max_x && min_y <= pos_y && pos_y <= max_y)
        else $error("position outside bounds");

    // The bounds always include the origin.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> min_x <= 0 && max_x >= 0 && min_y <= 0 && max_y >= 0)
        else $error("bounds exclude origin");

    // An ignored stack command neither draws nor jumps, and drawing is never a jump.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(segment_drawn && pen_jump)
                      && (status == STAT_OK || (!segment_drawn && !pen_jump)))
        else $error("inconsistent result flags");

endmodule

bind turtle_path_bounds_tracker_core tpbt_checker u_tpbt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .pos_x         (res.pos_x),
    .pos_y         (res.pos_y),
    .segment_drawn (res.segment_drawn),
    .pen_jump      (res.pen_jump),
    .min_x         (res.min_x),
    .max_x         (res.max_x),
    .min_y         (res.min_y),
    .max_y         (res.max_y),
    .status        (res.status)
);

// ----- dv/tb_turtle_path_bounds_tracker_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the turtle path bounds tracker core.
module tb_turtle_path_bounds_tracker_core;
    import tpbt_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_MAX     = 10;
    localparam int RUN_MOVES      = 64;
    localparam int IDLE_PCT       = 12;

    typedef struct packed {
        logic [7:0] ch;
        logic       rs;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               segment_drawn;
        logic               pen_jump;
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        tpbt_status_t       status;
    } turtle_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    tpbt_cmd_if cmd_ch();
    tpbt_res_if res_ch();

    turtle_path_bounds_tracker_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted turtle state and register copies.
    logic [15:0] turn_step_cfg;
    logic [15:0] start_heading_cfg;
    int          turtle_x;
    int          turtle_y;
    logic [15:0] turtle_heading;
    int          box_lo_x;
    int          box_hi_x;
    int          box_lo_y;
    int          box_hi_y;
    int          saved_x [TPBT_STACK_DEPTH];
    int          saved_y [TPBT_STACK_DEPTH];
    logic [15:0] saved_heading [TPBT_STACK_DEPTH];
    int          stack_fill;

    // Pending command words and the result words they should produce.
    cmd_word_t    cmd_backlog [$];
    turtle_word_t expected_words [$];
    cmd_word_t    offered_word;
    turtle_word_t got_word;
    turtle_word_t want_word;

    int src_idle_pct   = IDLE_PCT;
    int snk_stall_pct  = IDLE_PCT;
    bit sender_hold    = 1'b0;
    int words_sent     = 0;
    int words_checked  = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int holdoff_left   = 0;
    int moves_seen     = 0;
    int draws_seen     = 0;
    int push_full_seen = 0;
    int pop_empty_seen = 0;
    int clamp_hits     = 0;
    int restarts_seen  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Turtle back at the origin with an empty stack and a zero bounding box.
    function automatic void restart_turtle();
        turtle_x       = 0;
        turtle_y       = 0;
        turtle_heading = start_heading_cfg;
        box_lo_x       = 0;
        box_hi_x       = 0;
        box_lo_y       = 0;
        box_hi_y       = 0;
        stack_fill     = 0;
    endfunction

    // Saturate an exact coordinate sum to the signed Q16.16 range.
    function automatic int clamp_q16(input longint v);
        if (v > 64'sd2147483647)
        begin
            clamp_hits++;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            clamp_hits++;
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    // Apply one command word to the predicted turtle and return its result word.
    function automatic turtle_word_t advance_turtle(input logic [7:0] ch, input logic rs);
        turtle_word_t w;
        logic [31:0]  ang;
        logic [31:0]  probe;
        logic         flip;
        longint       xv;
        longint       yv;
        longint       zv;
        longint       sx;
        longint       sy;
        longint       step_atan;
        int           ox;
        int           oy;
        w = '0;
        w.status = STAT_OK;
        if (rs)
        begin
            restart_turtle();
            restarts_seen++;
        end
        ox = turtle_x;
        oy = turtle_y;
        if (ch == CH_DRAW || ch == CH_SKIP)
        begin
            // CORDIC rotation of the heading; the left half-plane is folded over.
            ang   = {turtle_heading, 16'h0000};
            probe = ang + 32'h4000_0000;
            flip  = probe[31];
            if (flip)
                ang = ang + 32'h8000_0000;
            zv = $signed(ang);
            xv = 64'sd652032874;
            yv = 0;
            for (int i = 0; i < TPBT_CORDIC_STEPS && i < 24; i++)
            begin
                case (i)
                    0:       step_atan = 64'h2000_0000;
                    1:       step_atan = 64'h12E4_051D;
                    2:       step_atan = 64'h09FB_385B;
                    3:       step_atan = 64'h0511_11D4;
                    4:       step_atan = 64'h028B_0D43;
                    5:       step_atan = 64'h0145_D7E1;
                    6:       step_atan = 64'h00A2_F61E;
                    7:       step_atan = 64'h0051_7C55;
                    8:       step_atan = 64'h0028_BE53;
                    9:       step_atan = 64'h0014_5F2F;
                    10:      step_atan = 64'h000A_2F98;
                    11:      step_atan = 64'h0005_17CC;
                    12:      step_atan = 64'h0002_8BE6;
                    13:      step_atan = 64'h0001_45F3;
                    14:      step_atan = 64'h0000_A2F9;
                    15:      step_atan = 64'h0000_517C;
                    16:      step_atan = 64'h0000_28BE;
                    17:      step_atan = 64'h0000_145F;
                    18:      step_atan = 64'h0000_0A2F;
                    19:      step_atan = 64'h0000_0517;
                    20:      step_atan = 64'h0000_028B;
                    21:      step_atan = 64'h0000_0145;
                    22:      step_atan = 64'h0000_00A2;
                    default: step_atan = 64'h0000_0051;
                endcase
                sx = yv >>> i;
                sy = xv >>> i;
                if (zv >= 0)
                begin
                    xv = xv - sx;
                    yv = yv + sy;
                    zv = zv - step_atan;
                end
                else
                begin
                    xv = xv + sx;
                    yv = yv - sy;
                    zv = zv + step_atan;
                end
            end
            if (flip)
            begin
                xv = -xv;
                yv = -yv;
            end
            // Round Q2.30 down to Q16.16 and take the saturating step.
            turtle_x = clamp_q16(longint'(turtle_x) + ((xv + 8192) >>> 14));
            turtle_y = clamp_q16(longint'(turtle_y) + ((yv + 8192) >>> 14));
            if (turtle_x < box_lo_x) box_lo_x = turtle_x;
            if (turtle_x > box_hi_x) box_hi_x = turtle_x;
            if (turtle_y < box_lo_y) box_lo_y = turtle_y;
            if (turtle_y > box_hi_y) box_hi_y = turtle_y;
            moves_seen++;
            if (ch == CH_DRAW)
            begin
                w.segment_drawn = 1'b1;
                draws_seen++;
            end
            else
                w.pen_jump = (turtle_x != ox || turtle_y != oy);
        end
        else if (ch == CH_LEFT)
            turtle_heading = turtle_heading + turn_step_cfg;
        else if (ch == CH_RIGHT)
            turtle_heading = turtle_heading - turn_step_cfg;
        else if (ch == CH_PUSH)
        begin
            if (stack_fill >= TPBT_STACK_DEPTH)
            begin
                w.status = STAT_PUSH_FULL;
                push_full_seen++;
            end
            else
            begin
                saved_x[stack_fill]       = turtle_x;
                saved_y[stack_fill]       = turtle_y;
                saved_heading[stack_fill] = turtle_heading;
                stack_fill++;
            end
        end
        else if (ch == CH_POP)
        begin
            if (stack_fill == 0)
            begin
                w.status = STAT_POP_EMPTY;
                pop_empty_seen++;
            end
            else
            begin
                // The restored point was counted in the bounds already.
                stack_fill--;
                turtle_x       = saved_x[stack_fill];
                turtle_y       = saved_y[stack_fill];
                turtle_heading = saved_heading[stack_fill];
                w.pen_jump     = (turtle_x != ox || turtle_y != oy);
            end
        end
        w.pos_x = turtle_x;
        w.pos_y = turtle_y;
        w.min_x = box_lo_x;
        w.max_x = box_hi_x;
        w.min_y = box_lo_y;
        w.max_y = box_hi_y;
        return w;
    endfunction

    // Command driver: offers words from the backlog and predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.cmd_char <= 8'h00;
            cmd_ch.restart  <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_words.push_back(advance_turtle(cmd_ch.cmd_char, cmd_ch.restart));
                words_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (!sender_hold && cmd_backlog.size() != 0
                    && $urandom_range(99) >= src_idle_pct)
                begin
                    offered_word = cmd_backlog.pop_front();
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.cmd_char <= offered_word.ch;
                    cmd_ch.restart  <= offered_word.rs;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            holdoff_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got_word = {res_ch.pos_x, res_ch.pos_y, res_ch.segment_drawn, res_ch.pen_jump,
                            res_ch.min_x, res_ch.max_x, res_ch.min_y, res_ch.max_y,
                            res_ch.status};
                words_checked++;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result word %0d arrived with nothing expected",
                                 $realtime, words_checked);
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (got_word !== want_word)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: result word %0d mismatch", $realtime, words_checked);
                            $display({"  expected x=%0d y=%0d draw=%b jump=%b",
                                      " box=%0d..%0d,%0d..%0d st=%0d"},
                                     want_word.pos_x, want_word.pos_y, want_word.segment_drawn,
                                     want_word.pen_jump, want_word.min_x, want_word.max_x,
                                     want_word.min_y, want_word.max_y, want_word.status);
                            $display({"  actual   x=%0d y=%0d draw=%b jump=%b",
                                      " box=%0d..%0d,%0d..%0d st=%0d"},
                                     got_word.pos_x, got_word.pos_y, got_word.segment_drawn,
                                     got_word.pen_jump, got_word.min_x, got_word.max_x,
                                     got_word.min_y, got_word.max_y, got_word.status);
                        end
                    end
                end
                // Two long back-pressure stretches so the core fills up and stalls its input.
                if (words_checked == 200 || words_checked == 1500)
                    holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("tb_turtle_path_bounds_tracker_core NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [7:0] ch, input logic rs);
        cmd_word_t w;
        w.ch = ch;
        w.rs = rs;
        cmd_backlog.push_back(w);
    endtask

    // Random turtle programs: mostly nested branches of moves and turns, some noise.
    task automatic queue_program(input int count);
        int        depth;
        int        pick;
        cmd_word_t w;
        depth = 0;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(999);
            w.rs = ($urandom_range(59) == 0);
            if (w.rs)
                depth = 0;
            if (pick < 300)
                w.ch = CH_DRAW;
            else if (pick < 400)
                w.ch = CH_SKIP;
            else if (pick < 530)
                w.ch = CH_LEFT;
            else if (pick < 660)
                w.ch = CH_RIGHT;
            else if (pick < 780 || (pick < 900 && depth == 0))
            begin
                w.ch = CH_PUSH;
                depth++;
            end
            else if (pick < 940)
            begin
                // Pops above the branch range are stray and may find the stack empty.
                w.ch = CH_POP;
                depth = (depth > 0) ? depth - 1 : 0;
            end
            else
                w.ch = 8'($urandom_range(255));
            cmd_backlog.push_back(w);
        end
    endtask

    // Wait until every queued word was sent and every result word has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid || expected_words.size() != 0);
    endtask

    // One register write: setup cycle, access cycle, then release.
    task automatic apb_write(input logic idx, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TURN_ANGLE)
            turn_step_cfg = val;
        else
            start_heading_cfg = val;
    endtask

    // Reprogram both registers once the core is idle.
    task automatic load_regs(input logic [15:0] turn, input logic [15:0] start);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(REG_TURN_ANGLE, turn);
        apb_write(REG_START_HEADING, start);
        @(negedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd_char = 8'h00;
        cmd_ch.restart  = 1'b0;
        res_ch.ready    = 1'b0;
        turn_step_cfg     = TURN_ANGLE_RST;
        start_heading_cfg = START_HEADING_RST;
        restart_turtle();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at reset settings: every command, ignored bytes, pops and restarts.
        queue_word(CH_POP, 1'b0);
        queue_word(CH_RIGHT, 1'b0);
        queue_word(CH_DRAW, 1'b0);
        queue_word(CH_PUSH, 1'b0);
        queue_word(CH_LEFT, 1'b0);
        queue_word(CH_DRAW, 1'b0);
        queue_word(CH_SKIP, 1'b0);
        queue_word(CH_POP, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h7F, 1'b1);
        queue_word(CH_DRAW, 1'b1);
        queue_word(CH_PUSH, 1'b0);
        queue_word(CH_POP, 1'b1);
        queue_word(CH_PUSH, 1'b0);
        queue_word(CH_POP, 1'b0);
        queue_word(CH_SKIP, 1'b0);
        queue_word(CH_SKIP, 1'b0);
        queue_word(8'h80, 1'b0);

        // Largest turn and start heading: each directed turn wraps the heading.
        load_regs(16'hFFFF, 16'hFFFF);
        queue_word(CH_DRAW, 1'b1);
        queue_word(CH_LEFT, 1'b0);
        queue_word(CH_LEFT, 1'b0);
        queue_word(CH_RIGHT, 1'b0);
        queue_word(CH_DRAW, 1'b0);
        queue_program(350);

        // Zero turn and heading with no idling on either side.
        load_regs(16'h0000, 16'h0000);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        queue_word(CH_DRAW, 1'b1);
        queue_program(350);

        // Random settings; halfway through, the sender pauses until all results are in.
        load_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)));
        src_idle_pct  = IDLE_PCT;
        snk_stall_pct = IDLE_PCT;
        queue_word(CH_SKIP, 1'b1);
        queue_program(350);
        do
            @(negedge clk);
        while (cmd_backlog.size() >= 175);
        sender_hold = 1'b1;
        do
            @(negedge clk);
        while (cmd_ch.valid || expected_words.size() != 0);
        repeat (5) @(negedge clk);
        sender_hold = 1'b0;

        // Stack overflow and underflow in one deep branch.
        load_regs(16'h4000, 16'h8000);
        queue_word(CH_DRAW, 1'b1);
        for (int n = 0; n < TPBT_STACK_DEPTH + 4; n++)
        begin
            queue_word(CH_PUSH, 1'b0);
            queue_word(($urandom_range(1) == 1) ? CH_DRAW : CH_LEFT, 1'b0);
        end
        for (int n = 0; n < TPBT_STACK_DEPTH + 4; n++)
            queue_word(CH_POP, 1'b0);

        // Straight run along x at full rate.
        load_regs(16'h0000, 16'h0000);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        queue_word(CH_DRAW, 1'b1);
        for (int n = 0; n < RUN_MOVES; n++)
            queue_word(($urandom_range(1) == 1) ? CH_DRAW : CH_SKIP, 1'b0);
        queue_word(CH_SKIP, 1'b0);
        queue_word(CH_PUSH, 1'b0);
        queue_word(CH_POP, 1'b0);

        // Back to the reset settings.
        load_regs(TURN_ANGLE_RST, START_HEADING_RST);
        src_idle_pct  = IDLE_PCT;
        snk_stall_pct = IDLE_PCT;
        queue_word(CH_DRAW, 1'b1);
        queue_program(350);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatches = mismatches + expected_words.size();

        $display("Ran %0d command words and checked %0d result words: %0d moves, %0d drawn,",
                 words_sent, words_checked, moves_seen, draws_seen);
        $display("%0d restarts, %0d full-stack pushes, %0d empty pops, %0d saturated, %0d bad.",
                 restarts_seen, push_full_seen, pop_empty_seen, clamp_hits, mismatches);
        if (mismatches == 0)
            $display("tb_turtle_path_bounds_tracker_core OK");
        else
            $display("tb_turtle_path_bounds_tracker_core NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tpbt_pkg.sv
rtl/tpbt_if.sv
rtl/tpbt_ctrl.sv
rtl/tpbt_dp.sv
rtl/turtle_path_bounds_tracker_core.sv
rtl/tpbt_checker.sv
dv/tb_turtle_path_bounds_tracker_core.sv
